@@ rtl/aoc_pkg.sv @@
package aoc_pkg;

    localparam int unsigned NUM_CH = 3;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned PROD_W = 16;
    localparam int unsigned NUM_W  = 17;
    localparam int unsigned PIX_W  = 32;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hff;

    // One classified pixel as it travels from the front end to the divider.
    typedef struct packed {
        logic [NUM_CH-1:0][NUM_W-1:0] num;
        logic [NUM_CH-1:0]            sat;
        logic [BYTE_W-1:0]            ao;
        logic                         zero;
        logic                         last;
    } aoc_item_t;

    // Rounded division by 255 for products of two bytes.
    function automatic logic [BYTE_W-1:0] div255_round(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        logic [PROD_W:0] s;
        t = {1'b0, x} + (PROD_W+1)'(128);
        s = {{BYTE_W{1'b0}}, t[PROD_W:BYTE_W]} + t;
        return s[PROD_W-1:BYTE_W];
    endfunction

endpackage

@@ rtl/aoc_front.sv @@
module aoc_front
    import aoc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PIX_W-1:0] fg_pixel,
    input  logic [PIX_W-1:0] bg_pixel,
    input  logic             last_in,
    output logic             out_valid,
    input  logic             out_ready,
    output aoc_item_t        out_item
);

    typedef struct packed {
        logic [BYTE_W-1:0]             a1;
        logic [BYTE_W-1:0]             w;
        logic [PROD_W-1:0]             p_aw;
        logic [NUM_CH-1:0][PROD_W-1:0] p_c2a2;
        logic [NUM_CH-1:0][PROD_W-1:0] p_c1a1;
        logic                          last;
    } s1_t;

    typedef struct packed {
        logic [BYTE_W-1:0]             ao;
        logic [NUM_CH-1:0][PROD_W-1:0] m;
        logic [NUM_CH-1:0][PROD_W-1:0] c1a1;
        logic                          last;
    } s2_t;

    s1_t       s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    aoc_item_t s3_reg, s3_next;
    logic      v1_reg, v2_reg, v3_reg;
    logic      en1, en2, en3;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Stage 1: byte products.
    always_comb begin
        logic [BYTE_W-1:0] a1;
        logic [BYTE_W-1:0] a2;
        logic [BYTE_W-1:0] w;
        a1 = fg_pixel[PIX_W-1 -: BYTE_W];
        a2 = bg_pixel[PIX_W-1 -: BYTE_W];
        w  = BYTE_MAX - a1;
        s1_next.a1   = a1;
        s1_next.w    = w;
        s1_next.p_aw = a2 * w;
        for (int b = 0; b < NUM_CH; b++) begin
            s1_next.p_c2a2[b] = bg_pixel[b*BYTE_W +: BYTE_W] * a2;
            s1_next.p_c1a1[b] = fg_pixel[b*BYTE_W +: BYTE_W] * a1;
        end
        s1_next.last = last_in;
    end

    // Stage 2: output alpha and the background term scaled by w.
    always_comb begin
        logic [BYTE_W:0] ao_sum;
        ao_sum = {1'b0, s1_reg.a1} + {1'b0, div255_round(s1_reg.p_aw)};
        s2_next.ao = ao_sum[BYTE_W] ? BYTE_MAX : ao_sum[BYTE_W-1:0];
        for (int b = 0; b < NUM_CH; b++) begin
            s2_next.m[b]    = div255_round(s1_reg.p_c2a2[b]) * s1_reg.w;
            s2_next.c1a1[b] = s1_reg.p_c1a1[b];
        end
        s2_next.last = s1_reg.last;
    end

    // Stage 3: numerators, and whether each quotient will saturate.
    always_comb begin
        for (int b = 0; b < NUM_CH; b++) begin
            s3_next.num[b] = {1'b0, s2_reg.c1a1[b]} + {1'b0, s2_reg.m[b]};
            s3_next.sat[b] = s3_next.num[b][NUM_W-1:BYTE_W] >= {1'b0, s2_reg.ao};
        end
        s3_next.ao   = s2_reg.ao;
        s3_next.zero = s2_reg.ao == '0;
        s3_next.last = s2_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en3) s3_reg <= s3_next;
    end

    assign out_valid = v3_reg;
    assign out_item  = s3_reg;

endmodule

@@ rtl/aoc_fifo.sv @@
module aoc_fifo
    import aoc_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  aoc_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output aoc_item_t out_item
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    aoc_item_t         mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              push, pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

@@ rtl/aoc_divider.sv @@
module aoc_divider
    import aoc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  aoc_item_t        in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_pixel,
    output logic             last_out
);

    localparam int unsigned NSTAGE = BYTE_W;

    typedef struct packed {
        logic [NUM_CH-1:0][NUM_W-1:0]  rem;
        logic [NUM_CH-1:0][BYTE_W-1:0] q;
        logic [NUM_CH-1:0]             sat;
        logic [BYTE_W-1:0]             ao;
        logic                          zero;
        logic                          last;
    } div_stage_t;

    div_stage_t stage_reg  [NSTAGE];
    div_stage_t stage_next [NSTAGE];
    div_stage_t stage_src  [NSTAGE];
    logic       valid_reg  [NSTAGE];
    logic       en         [NSTAGE+1];

    assign en[NSTAGE] = out_ready;
    assign in_ready   = en[0];

    // The first stage is loaded from the queue; a channel that does not saturate
    // needs only the quotient bits that fit a byte, so the divider runs 8 steps.
    always_comb begin
        for (int b = 0; b < NUM_CH; b++) begin
            stage_src[0].rem[b] = in_item.num[b];
            stage_src[0].q[b]   = '0;
        end
        stage_src[0].sat  = in_item.sat;
        stage_src[0].ao   = in_item.ao;
        stage_src[0].zero = in_item.zero;
        stage_src[0].last = in_item.last;
    end

    for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
        localparam int unsigned BIT = NSTAGE - 1 - k;

        if (k > 0) begin : g_link
            assign stage_src[k] = stage_reg[k-1];
        end

        assign en[k] = !valid_reg[k] || en[k+1];

        always_comb begin
            logic [NUM_W-1:0] d_sh;
            d_sh = NUM_W'(stage_src[k].ao) << BIT;
            stage_next[k] = stage_src[k];
            for (int b = 0; b < NUM_CH; b++) begin
                if (stage_src[k].rem[b] >= d_sh) begin
                    stage_next[k].rem[b]    = stage_src[k].rem[b] - d_sh;
                    stage_next[k].q[b][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en[k]) begin
                if (k == 0) begin
                    valid_reg[k] <= in_valid;
                end else begin
                    valid_reg[k] <= valid_reg[k > 0 ? k-1 : 0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) stage_reg[k] <= stage_next[k];
        end
    end

    always_comb begin
        out_pixel = '0;
        out_pixel[PIX_W-1 -: BYTE_W] = stage_reg[NSTAGE-1].ao;
        for (int b = 0; b < NUM_CH; b++) begin
            if (stage_reg[NSTAGE-1].zero) begin
                out_pixel[b*BYTE_W +: BYTE_W] = '0;
            end else if (stage_reg[NSTAGE-1].sat[b]) begin
                out_pixel[b*BYTE_W +: BYTE_W] = BYTE_MAX;
            end else begin
                out_pixel[b*BYTE_W +: BYTE_W] = stage_reg[NSTAGE-1].q[b];
            end
        end
    end

    assign out_valid = valid_reg[NSTAGE-1];
    assign last_out  = stage_reg[NSTAGE-1].last;

endmodule

@@ rtl/alpha_over_composite_unit.sv @@
// Porter-Duff over compositing of straight-alpha RGBA8888 pixels, alpha in
// byte 3. The block takes one foreground/background pair per clock and
// returns one composited pixel per clock while neither side stalls, with the
// frame end mark carried alongside. From input transaction to result, three
// front-end stages form the output alpha and the color numerators, the queue
// holds the item in its register file, and an eight-stage restoring divider
// produces one quotient bit per stage for all three color channels at once.
// The queue of QUEUE_DEPTH entries absorbs short stalls so the front end and
// the divider can hold independently.
module alpha_over_composite_unit
    import aoc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_fg_pixel,
    input  logic [PIX_W-1:0] s_bg_pixel,
    input  logic             s_last_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_out_pixel,
    output logic             m_last_out
);

    logic      front_valid, front_ready;
    aoc_item_t front_item;
    logic      queue_valid, queue_ready;
    aoc_item_t queue_item;

    aoc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .fg_pixel  (s_fg_pixel),
        .bg_pixel  (s_bg_pixel),
        .last_in   (s_last_in),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    aoc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    aoc_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (queue_valid),
        .in_ready  (queue_ready),
        .in_item   (queue_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pixel (m_out_pixel),
        .last_out  (m_last_out)
    );

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import aoc_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1630;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned DRAIN_CYCLES   = 30;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned MAX_PRINTS     = 40;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    class over_scoreboard;
        logic [PIX_W-1:0] expected_pixel[$];
        logic             expected_last[$];
        int unsigned      errors;
        int unsigned      n_in;
        int unsigned      n_out;
        int unsigned      n_frames;
        int unsigned      n_clear;
        int unsigned      n_sat;

        function int unsigned round_div255(input int unsigned x);
            int unsigned t;
            t = x + 128;
            return ((t >> 8) + t) >> 8;
        endfunction

        // Straight-alpha over operator; sat tells whether any color byte clipped.
        function void composite_over(input logic [PIX_W-1:0] fg, input logic [PIX_W-1:0] bg,
                                     output logic [PIX_W-1:0] px, output bit sat);
            int unsigned a1;
            int unsigned a2;
            int unsigned w;
            int unsigned ao;
            int unsigned c1;
            int unsigned c2;
            int unsigned num;
            int unsigned q;
            a1 = 32'(fg[31:24]);
            a2 = 32'(bg[31:24]);
            w = 255 - a1;
            ao = a1 + round_div255(a2 * w);
            if (ao > 255) ao = 255;
            px = '0;
            px[31:24] = ao[7:0];
            sat = 1'b0;
            if (ao != 0) begin
                for (int b = 0; b < NUM_CH; b++) begin
                    c1 = (fg >> (8 * b)) & 32'hff;
                    c2 = (bg >> (8 * b)) & 32'hff;
                    num = c1 * a1 + round_div255(c2 * a2) * w;
                    q = num / ao;
                    if (q > 255) begin
                        q = 255;
                        sat = 1'b1;
                    end
                    px[8*b +: 8] = q[7:0];
                end
            end
        endfunction

        function void note_input(input logic [PIX_W-1:0] fg, input logic [PIX_W-1:0] bg,
                                 input logic last);
            logic [PIX_W-1:0] px;
            bit               sat;
            composite_over(fg, bg, px, sat);
            expected_pixel.push_back(px);
            expected_last.push_back(last);
            n_in++;
            if (last) n_frames++;
            if (px[31:24] == 8'h00) n_clear++;
            if (sat) n_sat++;
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_result(input logic [PIX_W-1:0] px, input logic last);
            logic [PIX_W-1:0] want_px;
            logic             want_last;
            if (expected_pixel.size() == 0) begin
                report_mismatch($sformatf("result %h/%b with no transaction pending", px, last));
            end else begin
                want_px = expected_pixel.pop_front();
                want_last = expected_last.pop_front();
                if (px !== want_px)
                    report_mismatch($sformatf("result %0d out_pixel %h, expected %h",
                                              n_out, px, want_px));
                if (last !== want_last)
                    report_mismatch($sformatf("result %0d last_out %b, expected %b",
                                              n_out, last, want_last));
            end
            n_out++;
        endtask

        function int unsigned pending();
            return expected_pixel.size();
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [PIX_W-1:0] s_fg_pixel;
    logic [PIX_W-1:0] s_bg_pixel;
    logic             s_last_in;
    logic             m_valid;
    logic             m_ready;
    logic [PIX_W-1:0] m_out_pixel;
    logic             m_last_out;

    over_scoreboard sb;
    bit             hold_req;
    bit             hold_seen;
    int unsigned    quiet_cycles;

    alpha_over_composite_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_fg_pixel  (s_fg_pixel),
        .s_bg_pixel  (s_bg_pixel),
        .s_last_in   (s_last_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_pixel (m_out_pixel),
        .m_last_out  (m_last_out)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_fg_pixel, s_bg_pixel, s_last_in);
            if (m_valid && m_ready) sb.check_result(m_out_pixel, m_last_out);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Result side: phases of different stall patterns, plus one long hold on request.
    initial begin
        rx_mode_t    mode;
        int unsigned phase_left;
        int unsigned tick;
        mode = RX_ALWAYS;
        phase_left = 0;
        tick = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_req = 1'b0;
                hold_seen = 1'b1;
            end else begin
                if (phase_left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    phase_left = $urandom_range(10, 120);
                end
                phase_left--;
                tick++;
                case (mode)
                    RX_ALWAYS:   m_ready <= 1'b1;
                    RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: m_ready <= (tick % 5 != 0);
                    default:     m_ready <= 1'b1;
                endcase
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task send_item(input logic [PIX_W-1:0] fg, input logic [PIX_W-1:0] bg, input logic last);
        s_valid <= 1'b1;
        s_fg_pixel <= fg;
        s_bg_pixel <= bg;
        s_last_in <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task idle_cycles(input int unsigned n);
        s_valid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'($urandom_range(1, 4));
            3:       return 8'($urandom_range(251, 254));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        logic [PIX_W-1:0] r;
        r = $urandom();
        // Bright colors make the clipped quotient far more likely.
        if ($urandom_range(0, 7) == 0) r[23:0] = {3{8'($urandom_range(250, 255))}};
        r[31:24] = pick_alpha();
        return r;
    endfunction

    initial begin
        int unsigned burst_left;
        int unsigned frame_len;
        int unsigned frame_pos;
        logic        last;
        sb = new();
        hold_req = 1'b0;
        hold_seen = 1'b0;
        quiet_cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_fg_pixel = '0;
        s_bg_pixel = '0;
        s_last_in = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: zero output alpha, opaque and clear layers, extremes, clipping.
        send_item(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_item(32'h00ff_ffff, 32'h00ff_ffff, 1'b1);
        send_item(32'hffff_ffff, 32'h0000_0000, 1'b0);
        send_item(32'hff12_3456, 32'hffab_cdef, 1'b0);
        send_item(32'h0012_3456, 32'hffab_cdef, 1'b1);
        send_item(32'h0000_0000, 32'hffff_ffff, 1'b0);
        send_item(32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_item(32'h80ff_00ff, 32'h8000_ff00, 1'b0);
        send_item(32'h01ff_ffff, 32'h01ff_ffff, 1'b0);
        send_item(32'h01ff_ffff, 32'h00ff_ffff, 1'b0);
        send_item(32'h00ff_ffff, 32'h01ff_ffff, 1'b1);
        send_item(32'hfe00_0000, 32'hffff_ffff, 1'b0);
        send_item(32'h7fff_ffff, 32'h03ff_ffff, 1'b1);
        for (int i = 1; i <= 8; i++)
            send_item({8'(i - 1), 24'hffffff}, {8'(i * 31), 24'hfefefe}, 1'(i == 8));

        burst_left = 0;
        frame_len = 0;
        frame_pos = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 500) begin
                // Long receiver hold with the sender pushing back to back.
                hold_req = 1'b1;
                burst_left = 80;
            end else if (n == 1000) begin
                idle_cycles(1);
                while (sb.pending() > 0) @(negedge aclk);
            end
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            if (frame_pos == frame_len) begin
                frame_len = $urandom_range(1, 48);
                frame_pos = 0;
            end
            last = (frame_pos == frame_len - 1);
            frame_pos++;
            // Occasional stray or missing frame marks.
            if ($urandom_range(0, 9) == 0) last = 1'($urandom_range(0, 1));
            send_item(pick_pixel(), pick_pixel(), last);
        end

        s_valid <= 1'b0;
        while (sb.pending() > 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d pixels in, %0d out, %0d frame marks", sb.n_in, sb.n_out,
                 sb.n_frames);
        $display("%0d fully clear results, %0d with clipped color, long hold %s",
                 sb.n_clear, sb.n_sat, hold_seen ? "done" : "missed");
        if (sb.errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

@@ alpha_over_composite_unit.f @@
rtl/aoc_pkg.sv
rtl/aoc_front.sv
rtl/aoc_fifo.sv
rtl/aoc_divider.sv
rtl/alpha_over_composite_unit.sv
tb/sv/tb.sv
